// ===== rtl/ppts_pkg.sv =====
// Package with the request, result and task table types of the tick scheduler.
package ppts_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } ppts_cmd_e;

  typedef struct packed {
    ppts_cmd_e   cmd;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  priority_level;
  } ppts_req_t;

  typedef struct packed {
    logic        busy_res;
    logic [3:0]  run_slot;
    logic        finished;
    logic [15:0] completion_time;
    logic [15:0] turnaround_time;
    logic [15:0] waiting_time;
    logic        all_done;
  } ppts_res_t;

  // Field order sets the selection key: priority, then remaining, then arrival.
  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] remaining;
    logic [15:0] arrival;
    logic [15:0] burst;
  } ppts_task_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPD,
    ST_RES
  } ppts_state_e;

  localparam logic [15:0] TimeMax = 16'hFFFF;

endpackage

// ===== rtl/preemptive_priority_tick_scheduler.sv =====
// Preemptive priority tick scheduler: task table in memory, one slot scanned per cycle.
//
// Requests arrive on in_valid_i/in_stall_o with an in_req_i payload. A load request
// writes one slot of the task table and gives no result; loads to a slot index at or
// beyond SLOTS are dropped. A tick request scans the table one slot per cycle through
// a memory with a registered read port, keeping the best slot so far, then writes back
// the chosen slot's remaining time and forms the result. A tick passes through the
// scan, last, update and result states before its result is registered on
// out_valid_o/out_res_o, and no new request is taken until it is back in idle. Loads
// are accepted back to back.
// The result register is separate from the request side, so a waiting result does not
// block loads; a tick whose result finds the register still full and stalled waits
// until the receiver takes the earlier result.
// Reset clears the loaded and finished flags, the pending count and the time counter;
// the task memory is not cleared, as only loaded slots are ever eligible.
module preemptive_priority_tick_scheduler
  import ppts_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ppts_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ppts_res_t out_res_o
);

  localparam int SlotW = $clog2(SLOTS);
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam logic [SlotW-1:0] LastIdx = SlotW'(SLOTS - 1);

  ppts_state_e state_q, state_d;

  ppts_task_t mem_q [SLOTS];
  ppts_task_t rd_data_q;
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  ppts_task_t       mem_wdata;
  logic             rd_en;

  logic [SLOTS-1:0] loaded_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [15:0]      time_q;
  logic [SlotW-1:0] scan_idx_q, rd_idx_q, best_idx_q;
  logic             rd_vld_q, found_q, fin_q;
  ppts_task_t       best_q;
  logic [15:0]      turn_q;
  logic             out_valid_q;
  ppts_res_t        out_res_q;

  logic             accept, load_en, tick_en, out_free, out_load;
  logic [SlotW-1:0] load_idx;
  logic             elig, better;
  logic [15:0]      rem_dec, time_next;
  logic             upd_fin;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign load_idx    = SlotW'(in_req_i.slot);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  assign elig = rd_vld_q && loaded_q[rd_idx_q] && !done_q[rd_idx_q]
                && (rd_data_q.arrival <= time_q);
  assign better = !found_q
                  || ({rd_data_q.prio, rd_data_q.remaining, rd_data_q.arrival}
                      < {best_q.prio, best_q.remaining, best_q.arrival});
  assign rem_dec   = best_q.remaining - 16'd1;
  assign upd_fin   = found_q && (rem_dec == 16'd0);
  assign time_next = (time_q == TimeMax) ? time_q : time_q + 16'd1;

  always_comb begin
    state_d   = state_q;
    load_en   = 1'b0;
    tick_en   = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = load_idx;
    mem_wdata = '{prio: in_req_i.priority_level, remaining: in_req_i.burst_time,
                  arrival: in_req_i.arrival_time, burst: in_req_i.burst_time};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.cmd == CMD_LOAD) begin
            if (int'(in_req_i.slot) < SLOTS) begin
              load_en = 1'b1;
              mem_we  = 1'b1;
            end
          end else begin
            tick_en = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_idx_q == LastIdx) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx_q;
          mem_wdata = best_q;
          mem_wdata.remaining = rem_dec;
        end
        state_d = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      done_q      <= '0;
      cnt_q       <= '0;
      time_q      <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (load_en) begin
        loaded_q[load_idx] <= 1'b1;
        done_q[load_idx]   <= (in_req_i.burst_time == 16'd0);
        cnt_q <= cnt_q + CntW'(in_req_i.burst_time != 16'd0)
                 - CntW'(loaded_q[load_idx] && !done_q[load_idx]);
      end
      if (tick_en) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end else if (rd_en) begin
        scan_idx_q <= scan_idx_q + SlotW'(1);
      end
      if (elig && better) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_UPD) begin
        time_q <= time_next;
        fin_q  <= upd_fin;
        if (upd_fin) begin
          done_q[best_idx_q] <= 1'b1;
          cnt_q <= cnt_q - CntW'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q;
    if (elig && better) begin
      best_q     <= rd_data_q;
      best_idx_q <= rd_idx_q;
    end
    if (state_q == ST_UPD) begin
      turn_q <= time_next - best_q.arrival;
    end
    if (out_load) begin
      out_res_q.busy_res        <= found_q;
      out_res_q.run_slot        <= found_q ? 4'(best_idx_q) : 4'd0;
      out_res_q.finished        <= fin_q;
      out_res_q.completion_time <= fin_q ? time_q : 16'd0;
      out_res_q.turnaround_time <= fin_q ? turn_q : 16'd0;
      out_res_q.waiting_time    <= (fin_q && (turn_q >= best_q.burst))
                                   ? turn_q - best_q.burst : 16'd0;
      out_res_q.all_done        <= (cnt_q == '0);
    end
  end

`ifndef NO_ASSERTIONS
  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.cmd == CMD_TICK) |=> (state_q == ST_SCAN))
    else $error("accepted tick did not start a scan");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cnt_q) <= SLOTS))
    else $error("pending count exceeds the table size");

  a_pick_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && found_q) |-> (loaded_q[best_idx_q] && !done_q[best_idx_q]))
    else $error("chosen slot is not pending");

  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_res_o.finished || out_res_o.busy_res))
    else $error("completion reported on an idle tick");
`endif

endmodule

// ===== test/ppts_schedule_checker.sv =====
// Checker that predicts the tick scheduler's results and compares them with the block's output.
module ppts_schedule_checker
  import ppts_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  ppts_req_t in_req_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  ppts_res_t out_res_i,
  output int        mismatch_count_o,
  output int        pending_o
);

  logic        loaded_q [SLOTS];
  logic        done_q   [SLOTS];
  ppts_task_t  table_q  [SLOTS];
  logic [15:0] clock_now;
  ppts_res_t   expected_res_q [$];

  function automatic logic preferred(int a, int b);
    if (table_q[a].prio != table_q[b].prio) begin
      return table_q[a].prio < table_q[b].prio;
    end
    if (table_q[a].remaining != table_q[b].remaining) begin
      return table_q[a].remaining < table_q[b].remaining;
    end
    return table_q[a].arrival < table_q[b].arrival;
  endfunction

  function automatic void load_slot(ppts_req_t req);
    int s;
    s = req.slot;
    if (s < SLOTS) begin
      loaded_q[s]          = 1'b1;
      done_q[s]            = (req.burst_time == 16'd0);
      table_q[s].prio      = req.priority_level;
      table_q[s].remaining = req.burst_time;
      table_q[s].arrival   = req.arrival_time;
      table_q[s].burst     = req.burst_time;
    end
  endfunction

  function automatic ppts_res_t run_tick();
    ppts_res_t   res;
    int          pick;
    logic        found;
    logic [15:0] turn;
    res   = '0;
    pick  = 0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (loaded_q[i] && !done_q[i] && table_q[i].arrival <= clock_now) begin
        if (!found || preferred(i, pick)) begin
          pick  = i;
          found = 1'b1;
        end
      end
    end
    if (clock_now != TimeMax) begin
      clock_now = clock_now + 16'd1;
    end
    if (found) begin
      res.busy_res = 1'b1;
      res.run_slot = pick[3:0];
      table_q[pick].remaining = table_q[pick].remaining - 16'd1;
      if (table_q[pick].remaining == 16'd0) begin
        done_q[pick]        = 1'b1;
        res.finished        = 1'b1;
        res.completion_time = clock_now;
        turn                = clock_now - table_q[pick].arrival;
        res.turnaround_time = turn;
        res.waiting_time    = (turn >= table_q[pick].burst) ? turn - table_q[pick].burst : 16'd0;
      end
    end
    res.all_done = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (loaded_q[i] && !done_q[i]) begin
        res.all_done = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ppts_res_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        loaded_q[i] = 1'b0;
        done_q[i]   = 1'b0;
        table_q[i]  = '0;
      end
      clock_now = '0;
      expected_res_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_res_q.size() == 0) begin
          $error("Result accepted with no tick request outstanding.");
          mismatch_count_o++;
        end else begin
          exp_res = expected_res_q.pop_front();
          check_field("busy_res", exp_res.busy_res, out_res_i.busy_res);
          check_field("run_slot", exp_res.run_slot, out_res_i.run_slot);
          check_field("finished", exp_res.finished, out_res_i.finished);
          check_field("completion_time", exp_res.completion_time, out_res_i.completion_time);
          check_field("turnaround_time", exp_res.turnaround_time, out_res_i.turnaround_time);
          check_field("waiting_time", exp_res.waiting_time, out_res_i.waiting_time);
          check_field("all_done", exp_res.all_done, out_res_i.all_done);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.cmd == CMD_LOAD) begin
          load_slot(in_req_i);
        end else begin
          expected_res_q.push_back(run_tick());
        end
      end
      pending_o = expected_res_q.size();
    end
  end

endmodule

// ===== test/preemptive_priority_tick_scheduler_tb.sv =====
// Testbench top: drives load and tick requests into the scheduler and reports the verdict.
module preemptive_priority_tick_scheduler_tb;
  import ppts_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  ppts_req_t in_req_i;
  logic      out_valid_o;
  logic      out_stall_i;
  ppts_res_t out_res_o;
  int        mismatch_count;
  int        pending;
  logic      quiet;
  int        ticks_sent;

  preemptive_priority_tick_scheduler #(
    .SLOTS(16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  ppts_schedule_checker #(
    .SLOTS(16)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_req_i        (in_req_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_res_i       (out_res_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic ppts_req_t make_req(ppts_cmd_e c, logic [3:0] s, logic [15:0] a,
                                         logic [15:0] b, logic [7:0] p);
    ppts_req_t req;
    req.cmd            = c;
    req.slot           = s;
    req.arrival_time   = a;
    req.burst_time     = b;
    req.priority_level = p;
    return req;
  endfunction

  function automatic ppts_req_t random_tick();
    return make_req(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  function automatic int time_estimate();
    return (ticks_sent > 65535) ? 65535 : ticks_sent;
  endfunction

  task automatic send_request(ppts_req_t req);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    if (req.cmd == CMD_TICK) begin
      ticks_sent++;
    end
  endtask

  task automatic send_random_load();
    int          r;
    int          arr;
    logic [15:0] burst;
    logic [7:0]  prio;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      arr = time_estimate() + $urandom_range(0, 20);
      if (arr > 65535) begin
        arr = 65535;
      end
    end else if (r < 17) begin
      arr = $urandom_range(0, 65535);
    end else begin
      arr = $urandom_range(0, time_estimate());
    end
    r = $urandom_range(0, 19);
    if (r < 15) begin
      burst = 16'($urandom_range(1, 6));
    end else if (r < 17) begin
      burst = 16'd0;
    end else if (r < 19) begin
      burst = 16'($urandom_range(7, 40));
    end else begin
      burst = 16'($urandom_range(1, 65535));
    end
    prio = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    send_request(make_req(CMD_LOAD, 4'($urandom), arr[15:0], burst, prio));
  endtask

  // The receiver holds each result off for a drawn number of cycles in which a result is offered.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = draw_wait();
      if (n != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        while (n > 0) begin
          @(posedge clk_i);
          if (out_valid_o) begin
            n--;
          end
        end
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #200000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    quiet      = 1'b0;
    ticks_sent = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(make_req(CMD_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_request(make_req(CMD_LOAD, 4'd0, 16'd0, 16'd1, 8'd255));
    send_request(make_req(CMD_LOAD, 4'd15, 16'd0, 16'd2, 8'd0));
    repeat (3) send_request(random_tick());
    send_request(make_req(CMD_LOAD, 4'd3, 16'd0, 16'd0, 8'd0));
    send_request(make_req(CMD_LOAD, 4'd4, 16'd0, 16'd5, 8'd3));
    send_request(make_req(CMD_LOAD, 4'd5, 16'd0, 16'd2, 8'd3));
    send_request(make_req(CMD_LOAD, 4'd6, 16'd1, 16'd3, 8'd2));
    send_request(make_req(CMD_LOAD, 4'd7, 16'd0, 16'd3, 8'd2));
    send_request(make_req(CMD_LOAD, 4'd11, 16'd0, 16'd1, 8'd1));
    send_request(make_req(CMD_LOAD, 4'd12, 16'd0, 16'd1, 8'd1));
    send_request(make_req(CMD_LOAD, 4'd10, 16'hFFFF, 16'd1, 8'd0));
    repeat (8) send_request(random_tick());
    send_request(make_req(CMD_LOAD, 4'd4, 16'd2, 16'd1, 8'd0));
    repeat (2) send_request(random_tick());

    for (int i = 0; i < 1400; i++) begin
      if (i % 64 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) < 4) begin
        send_random_load();
      end else begin
        send_request(random_tick());
      end
    end
    quiet = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
